/* sv/pcs_pkg.sv */
// shared types, codes and helpers for the pulse channel with sweep
`default_nettype none

package pcs_pkg;

  // operation codes carried by a request
  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_READ   = 3'd1,
    OP_TICK   = 3'd2,
    OP_LENGTH = 3'd3,
    OP_SWEEP  = 3'd4,
    OP_ENV    = 3'd5
  } op_t;

  // channel register numbers
  localparam logic [2:0] REG_SWEEP  = 3'd0;
  localparam logic [2:0] REG_DUTY   = 3'd1;
  localparam logic [2:0] REG_ENV    = 3'd2;
  localparam logic [2:0] REG_PER_LO = 3'd3;
  localparam logic [2:0] REG_PER_HI = 3'd4;

  localparam logic [4:0] LEVEL_MID = 5'h0f;
  localparam logic [3:0] VOL_MAX   = 4'hf;
  localparam logic [7:0] READ_IDLE = 8'hff;

  // one result as it leaves the core
  typedef struct packed {
    logic [7:0]        read_data;
    logic signed [11:0] sample;
    logic              channel_on;
  } result_t;

  // eight-step duty pattern, one of four shapes
  function automatic logic duty_high(input logic [1:0] mode, input logic [2:0] pos);
    logic hi;
    unique case (mode)
      2'd0:    hi = (pos != 3'd7);
      2'd1:    hi = (pos != 3'd0) && (pos != 3'd7);
      2'd2:    hi = (pos != 3'd0) && (pos <= 3'd4);
      default: hi = (pos == 3'd0) || (pos == 3'd7);
    endcase
    return hi;
  endfunction

endpackage

`default_nettype wire

/* sv/pcs_core.sv */
// channel state and per-request next-state logic
`default_nettype none

module pcs_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire logic [2:0]          op,
  input  wire logic [2:0]          reg_index,
  input  wire logic [7:0]          write_data,
  output pcs_pkg::result_t         result
);

  logic [2:0]  sweep_pace_r, sweep_pace_nxt;
  logic        sweep_down_r, sweep_down_nxt;
  logic [2:0]  sweep_shift_r, sweep_shift_nxt;
  logic [1:0]  duty_mode_r, duty_mode_nxt;
  logic [5:0]  length_count_r, length_count_nxt;
  logic        dac_enabled_r, dac_enabled_nxt;
  logic [3:0]  start_volume_r, start_volume_nxt;
  logic        env_rising_r, env_rising_nxt;
  logic [2:0]  env_pace_r, env_pace_nxt;
  logic [10:0] base_period_r, base_period_nxt;
  logic [11:0] live_period_r, live_period_nxt;
  logic        length_enabled_r, length_enabled_nxt;
  logic        running_r, running_nxt;
  logic [3:0]  cur_volume_r, cur_volume_nxt;
  logic [11:0] period_timer_r, period_timer_nxt;
  logic [2:0]  duty_position_r, duty_position_nxt;
  logic [2:0]  sweep_counter_r, sweep_counter_nxt;
  logic [2:0]  env_counter_r, env_counter_nxt;

  logic [11:0] timer_inc;
  logic [2:0]  tick_pos;
  logic [3:0]  level;
  logic [4:0]  amp;
  logic [11:0] sweep_adj;
  logic [11:0] swept;
  logic [2:0]  sweep_cnt_inc;
  logic [2:0]  env_cnt_inc;
  logic [5:0]  length_inc;
  logic [10:0] base_wr;
  logic        dac_wr;
  logic [7:0]  rd;
  logic [11:0] smp;

  // datapath terms used by the op arms
  assign timer_inc     = period_timer_r + 12'd1;
  assign tick_pos      = timer_inc[11] ? duty_position_r + 3'd1 : duty_position_r;
  assign level         = pcs_pkg::duty_high(duty_mode_r, tick_pos) ? cur_volume_r : 4'd0;
  assign amp           = {level, 1'b0} - pcs_pkg::LEVEL_MID;
  assign sweep_adj     = live_period_r >> sweep_shift_r;
  assign swept         = sweep_down_r ? live_period_r - sweep_adj : live_period_r + sweep_adj;
  assign sweep_cnt_inc = sweep_counter_r + 3'd1;
  assign env_cnt_inc   = env_counter_r + 3'd1;
  assign length_inc    = length_count_r + 6'd1;
  assign base_wr       = (reg_index == pcs_pkg::REG_PER_LO) ?
                         {base_period_r[10:8], write_data} :
                         {write_data[2:0], base_period_r[7:0]};
  assign dac_wr        = (write_data[7:3] != 5'd0);

  always_comb begin
    sweep_pace_nxt     = sweep_pace_r;
    sweep_down_nxt     = sweep_down_r;
    sweep_shift_nxt    = sweep_shift_r;
    duty_mode_nxt      = duty_mode_r;
    length_count_nxt   = length_count_r;
    dac_enabled_nxt    = dac_enabled_r;
    start_volume_nxt   = start_volume_r;
    env_rising_nxt     = env_rising_r;
    env_pace_nxt       = env_pace_r;
    base_period_nxt    = base_period_r;
    live_period_nxt    = live_period_r;
    length_enabled_nxt = length_enabled_r;
    running_nxt        = running_r;
    cur_volume_nxt     = cur_volume_r;
    period_timer_nxt   = period_timer_r;
    duty_position_nxt  = duty_position_r;
    sweep_counter_nxt  = sweep_counter_r;
    env_counter_nxt    = env_counter_r;
    rd                 = pcs_pkg::READ_IDLE;
    smp                = 12'd0;

    unique case (op)
      pcs_pkg::OP_WRITE: begin
        unique case (reg_index)
          pcs_pkg::REG_SWEEP: begin
            sweep_pace_nxt  = write_data[6:4];
            sweep_down_nxt  = write_data[3];
            sweep_shift_nxt = write_data[2:0];
          end
          pcs_pkg::REG_DUTY: begin
            duty_mode_nxt    = write_data[7:6];
            length_count_nxt = write_data[5:0];
          end
          pcs_pkg::REG_ENV: begin
            dac_enabled_nxt  = dac_wr;
            start_volume_nxt = write_data[7:4];
            env_rising_nxt   = write_data[3];
            env_pace_nxt     = write_data[2:0];
            if (!dac_wr) begin
              running_nxt = 1'b0;
            end
          end
          pcs_pkg::REG_PER_LO: begin
            base_period_nxt = base_wr;
            if (sweep_pace_r == 3'd0) begin
              live_period_nxt = {1'b0, base_wr};
            end
          end
          pcs_pkg::REG_PER_HI: begin
            length_enabled_nxt = write_data[6];
            base_period_nxt    = base_wr;
            if (sweep_pace_r == 3'd0) begin
              live_period_nxt = {1'b0, base_wr};
            end
            // trigger
            if (dac_enabled_r && write_data[7]) begin
              running_nxt      = 1'b1;
              cur_volume_nxt   = start_volume_r;
              live_period_nxt  = {1'b0, base_wr};
              period_timer_nxt = {1'b0, base_wr};
            end
          end
          default: ;
        endcase
      end
      pcs_pkg::OP_READ: begin
        unique case (reg_index)
          pcs_pkg::REG_SWEEP:  rd = {1'b1, sweep_pace_r, sweep_down_r, sweep_shift_r};
          pcs_pkg::REG_DUTY:   rd = {duty_mode_r, 6'h3f};
          pcs_pkg::REG_ENV:    rd = {start_volume_r, env_rising_r, env_pace_r};
          pcs_pkg::REG_PER_HI: rd = {1'b1, length_enabled_r, 6'h3f};
          default:             rd = pcs_pkg::READ_IDLE;
        endcase
      end
      pcs_pkg::OP_TICK: begin
        if (running_r) begin
          period_timer_nxt  = timer_inc[11] ? live_period_r : timer_inc;
          duty_position_nxt = tick_pos;
          smp               = {amp, 7'd0};
        end
      end
      pcs_pkg::OP_LENGTH: begin
        if (length_enabled_r) begin
          length_count_nxt = length_inc;
          if (length_inc == 6'd0) begin
            running_nxt = 1'b0;
          end
        end
      end
      pcs_pkg::OP_SWEEP: begin
        if (running_r && sweep_pace_r != 3'd0) begin
          if (sweep_cnt_inc == sweep_pace_r) begin
            sweep_counter_nxt = 3'd0;
            live_period_nxt   = swept;
            if (swept[11]) begin
              running_nxt = 1'b0;
            end
          end else begin
            sweep_counter_nxt = sweep_cnt_inc;
          end
        end
      end
      pcs_pkg::OP_ENV: begin
        if (running_r && env_pace_r != 3'd0) begin
          if (env_cnt_inc == env_pace_r) begin
            env_counter_nxt = 3'd0;
            if (env_rising_r) begin
              if (cur_volume_r != pcs_pkg::VOL_MAX) begin
                cur_volume_nxt = cur_volume_r + 4'd1;
              end
            end else if (cur_volume_r != 4'd0) begin
              cur_volume_nxt = cur_volume_r - 4'd1;
            end
          end else begin
            env_counter_nxt = env_cnt_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_pace_r     <= '0;
      sweep_down_r     <= 1'b0;
      sweep_shift_r    <= '0;
      duty_mode_r      <= '0;
      length_count_r   <= '0;
      dac_enabled_r    <= 1'b0;
      start_volume_r   <= '0;
      env_rising_r     <= 1'b0;
      env_pace_r       <= '0;
      base_period_r    <= '0;
      live_period_r    <= '0;
      length_enabled_r <= 1'b0;
      running_r        <= 1'b0;
      cur_volume_r     <= '0;
      period_timer_r   <= '0;
      duty_position_r  <= '0;
      sweep_counter_r  <= '0;
      env_counter_r    <= '0;
    end else if (fire) begin
      sweep_pace_r     <= sweep_pace_nxt;
      sweep_down_r     <= sweep_down_nxt;
      sweep_shift_r    <= sweep_shift_nxt;
      duty_mode_r      <= duty_mode_nxt;
      length_count_r   <= length_count_nxt;
      dac_enabled_r    <= dac_enabled_nxt;
      start_volume_r   <= start_volume_nxt;
      env_rising_r     <= env_rising_nxt;
      env_pace_r       <= env_pace_nxt;
      base_period_r    <= base_period_nxt;
      live_period_r    <= live_period_nxt;
      length_enabled_r <= length_enabled_nxt;
      running_r        <= running_nxt;
      cur_volume_r     <= cur_volume_nxt;
      period_timer_r   <= period_timer_nxt;
      duty_position_r  <= duty_position_nxt;
      sweep_counter_r  <= sweep_counter_nxt;
      env_counter_r    <= env_counter_nxt;
    end
  end

  assign result.read_data  = rd;
  assign result.sample     = smp;
  assign result.channel_on = running_nxt;

endmodule

`default_nettype wire

/* sv/pulse_channel_with_sweep.sv */
// top level of the square-wave channel with sweep, envelope and length
`default_nettype none

// channel  | ports                                        | direction
// ---------+----------------------------------------------+----------
// request  | in_valid in_stall in_op in_reg_index         | in
//          | in_write_data                                |
// result   | out_valid out_stall out_read_data out_sample | out
//          | out_channel_on                               |
//
// one request per cycle while in_stall is low; its result appears in the output register on the
// next cycle, set by the single state update in pcs_core
// synchronous active-low reset clears all channel state and the output valid
// in_stall rises only while the output register holds a result and out_stall
// is high; otherwise a new request is taken every cycle

module pulse_channel_with_sweep (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_op,
  input  wire logic [2:0]         in_reg_index,
  input  wire logic [7:0]         in_write_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_read_data,
  output logic signed [11:0]      out_sample,
  output logic                    out_channel_on
);

  pcs_pkg::result_t core_result;
  pcs_pkg::result_t result_r;
  logic             out_valid_r;
  logic             in_fire;

  // output register is free when empty or being drained this cycle
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  // channel state plus all per-request logic
  pcs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (in_fire),
    .op         (in_op),
    .reg_index  (in_reg_index),
    .write_data (in_write_data),
    .result     (core_result)
  );

  // output register: valid is control, payload loads on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= core_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = result_r.read_data;
  assign out_sample     = result_r.sample;
  assign out_channel_on = result_r.channel_on;

`ifndef SYNTH
  // every accepted request leaves a result in the output register
  a_fire_fills : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // an empty output register never holds back the request side
  a_empty_no_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("request stalled while output register empty");

  // a nonzero sample only comes from a running channel
  a_sample_on : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sample != 12'sd0) |-> out_channel_on)
    else $error("nonzero sample while channel off");

  // only sample ticks produce sample values
  a_tick_only : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op != pcs_pkg::OP_TICK) |=> (out_sample == 12'sd0))
    else $error("sample on a non-tick request");

  // only reads return anything other than all ones
  a_read_only : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op != pcs_pkg::OP_READ) |=> (out_read_data == pcs_pkg::READ_IDLE))
    else $error("read data on a non-read request");
`endif

endmodule

`default_nettype wire

/* tb/pulse_channel_with_sweep_tb.sv */
`timescale 1ns / 100ps
// testbench for the pulse channel: request driver, stall generator and a predicting scoreboard

module pulse_channel_with_sweep_tb;

  localparam int          CLK_HALF    = 4;
  localparam int          RESET_CYCLES = 6;
  localparam int          REQUEST_GOAL = 1750;
  localparam logic [11:0] PERIOD_WRAP = 12'h800;
  localparam int          LEVEL_GAIN  = 128;

  // channel model plus the queue of results it has predicted
  class pulse_scoreboard;
    bit [2:0]  sw_pace, sw_shift, sw_count;
    bit        sw_down;
    bit [1:0]  duty_sel;
    bit [2:0]  duty_pos;
    bit [5:0]  len_count;
    bit        len_on, dac_on, running;
    bit [3:0]  vol_start, vol_now;
    bit        env_up;
    bit [2:0]  env_pace, env_count;
    bit [10:0] base_per;
    bit [11:0] live_per, per_timer;

    pcs_pkg::result_t predicted_results[$];
    int               errors;
    int               results_seen;

    task report_mismatch(string msg);
      errors++;
      $display("ERROR @%0t result %0d: %s", $time, results_seen, msg);
    endtask

    // apply one accepted request to the model and queue its result
    function void note_request(bit [2:0] op, bit [2:0] idx, bit [7:0] d);
      pcs_pkg::result_t res;
      bit [7:0]         duty_mask;
      bit [11:0]        adj;
      bit [3:0]         level;
      int               amp;
      res.read_data = pcs_pkg::READ_IDLE;
      res.sample    = '0;
      case (op)
        pcs_pkg::OP_WRITE: begin
          case (idx)
            pcs_pkg::REG_SWEEP: begin
              sw_pace  = d[6:4];
              sw_down  = d[3];
              sw_shift = d[2:0];
            end
            pcs_pkg::REG_DUTY: begin
              duty_sel  = d[7:6];
              len_count = d[5:0];
            end
            pcs_pkg::REG_ENV: begin
              dac_on    = (d[7:3] != 5'd0);
              vol_start = d[7:4];
              env_up    = d[3];
              env_pace  = d[2:0];
              if (!dac_on) running = 1'b0;
            end
            pcs_pkg::REG_PER_LO: begin
              base_per[7:0] = d;
              if (sw_pace == 3'd0) live_per = {1'b0, base_per};
            end
            pcs_pkg::REG_PER_HI: begin
              len_on         = d[6];
              base_per[10:8] = d[2:0];
              if (sw_pace == 3'd0) live_per = {1'b0, base_per};
              if (dac_on && d[7]) begin
                running   = 1'b1;
                vol_now   = vol_start;
                live_per  = {1'b0, base_per};
                per_timer = live_per;
              end
            end
            default: ;
          endcase
        end
        pcs_pkg::OP_READ: begin
          case (idx)
            pcs_pkg::REG_SWEEP:  res.read_data = {1'b1, sw_pace, sw_down, sw_shift};
            pcs_pkg::REG_DUTY:   res.read_data = {duty_sel, 6'h3f};
            pcs_pkg::REG_ENV:    res.read_data = {vol_start, env_up, env_pace};
            pcs_pkg::REG_PER_HI: res.read_data = {1'b1, len_on, 6'h3f};
            default:             res.read_data = pcs_pkg::READ_IDLE;
          endcase
        end
        pcs_pkg::OP_TICK: begin
          if (running) begin
            per_timer = per_timer + 12'd1;
            if (per_timer >= PERIOD_WRAP) begin
              per_timer = live_per;
              duty_pos  = duty_pos + 3'd1;
            end
            case (duty_sel)
              2'd0:    duty_mask = 8'h7f;
              2'd1:    duty_mask = 8'h7e;
              2'd2:    duty_mask = 8'h1e;
              default: duty_mask = 8'h81;
            endcase
            level      = duty_mask[duty_pos] ? vol_now : 4'd0;
            amp        = (int'(level) * 2 - int'(pcs_pkg::LEVEL_MID)) * LEVEL_GAIN;
            res.sample = amp[11:0];
          end
        end
        pcs_pkg::OP_LENGTH: begin
          if (len_on) begin
            len_count = len_count + 6'd1;
            if (len_count == 6'd0) running = 1'b0;
          end
        end
        pcs_pkg::OP_SWEEP: begin
          if (running && sw_pace != 3'd0) begin
            sw_count = sw_count + 3'd1;
            if (sw_count == sw_pace) begin
              sw_count = 3'd0;
              adj      = live_per >> sw_shift;
              live_per = sw_down ? live_per - adj : live_per + adj;
              if (live_per >= PERIOD_WRAP) running = 1'b0;
            end
          end
        end
        pcs_pkg::OP_ENV: begin
          if (running && env_pace != 3'd0) begin
            env_count = env_count + 3'd1;
            if (env_count == env_pace) begin
              env_count = 3'd0;
              if (env_up && vol_now != pcs_pkg::VOL_MAX) vol_now = vol_now + 4'd1;
              else if (!env_up && vol_now != 4'd0) vol_now = vol_now - 4'd1;
            end
          end
        end
        default: ;
      endcase
      res.channel_on = running;
      predicted_results.push_back(res);
    endfunction

    task check_result(logic [7:0] rd, logic signed [11:0] smp, logic on);
      pcs_pkg::result_t want;
      results_seen++;
      if (predicted_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = predicted_results.pop_front();
      if (rd !== want.read_data)
        report_mismatch($sformatf("read_data %02h, predicted %02h", rd, want.read_data));
      if (smp !== want.sample)
        report_mismatch($sformatf("sample %0d, predicted %0d", smp, want.sample));
      if (on !== want.channel_on)
        report_mismatch($sformatf("channel_on %b, predicted %b", on, want.channel_on));
    endtask
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_op = '0;
  logic [2:0]        in_reg_index = '0;
  logic [7:0]        in_write_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_read_data;
  logic signed [11:0] out_sample;
  logic              out_channel_on;

  pulse_scoreboard board;
  bit              quiet;          // set for stretches with no idling on either side
  int              requests_sent;  // requests that do real work
  bit              drained;

  pulse_channel_with_sweep dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_reg_index   (in_reg_index),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_sample     (out_sample),
    .out_channel_on (out_channel_on)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // idle length for either side: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // present one request after a random gap and hold it until it is taken;
  // valid stays high across back-to-back requests
  task automatic send_request(logic [2:0] op, logic [2:0] idx, logic [7:0] data);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_reg_index  <= idx;
    in_write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(op, idx, data);
    // undefined ops and writes past the last register change nothing
    if (op <= pcs_pkg::OP_ENV && !(op == pcs_pkg::OP_WRITE && idx > pcs_pkg::REG_PER_HI))
      requests_sent++;
  endtask

  // result side back-pressure, sampled by the block at each rising edge
  initial begin : stall_gen
    int n;
    @(posedge clk);
    forever begin
      n = idle_cycles();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
  end

  // every result taken at an edge is compared with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_read_data, out_sample, out_channel_on);
  end

  initial begin : stimulus
    int         run_len;
    int         r;
    logic [7:0] d;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    send_request(pcs_pkg::OP_TICK, pcs_pkg::REG_SWEEP, 8'h00);   // tick while the channel is off
    send_request(pcs_pkg::OP_READ, pcs_pkg::REG_SWEEP, 8'h00);   // reset value, unused bit set
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_SWEEP, 8'h00);  // sweep off
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_DUTY, 8'hff);   // duty mode three, length near wrap
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_ENV, 8'hf8);    // full volume, rising, idle
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_PER_LO, 8'hff);
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_PER_HI, 8'hc7); // top period, length on, trigger
    send_request(pcs_pkg::OP_TICK, pcs_pkg::REG_SWEEP, 8'h00);   // timer hits the end and reloads
    send_request(pcs_pkg::OP_TICK, pcs_pkg::REG_SWEEP, 8'h00);
    send_request(pcs_pkg::OP_READ, pcs_pkg::REG_DUTY, 8'h00);
    send_request(pcs_pkg::OP_READ, pcs_pkg::REG_PER_HI, 8'h00);
    send_request(pcs_pkg::OP_READ, 3'd7, 8'h00);                 // register index out of range
    send_request(pcs_pkg::OP_WRITE, 3'd6, 8'ha5);                // ignored write past the end
    send_request(3'd6, pcs_pkg::REG_ENV, 8'hff);                 // undefined ops
    send_request(3'd7, pcs_pkg::REG_PER_HI, 8'h00);
    send_request(pcs_pkg::OP_LENGTH, pcs_pkg::REG_SWEEP, 8'h00); // length wraps, channel stops
    send_request(pcs_pkg::OP_TICK, pcs_pkg::REG_SWEEP, 8'h00);
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_ENV, 8'h07);    // DAC bits cleared
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_PER_HI, 8'h80); // trigger refused, DAC off
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_ENV, 8'h0a);    // volume zero, rising, pace two
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_PER_HI, 8'h87);
    send_request(pcs_pkg::OP_ENV, pcs_pkg::REG_SWEEP, 8'h00);
    send_request(pcs_pkg::OP_ENV, pcs_pkg::REG_SWEEP, 8'h00);    // volume steps up from zero
    send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_SWEEP, 8'h11);  // pace one, upward, shift one
    send_request(pcs_pkg::OP_SWEEP, pcs_pkg::REG_SWEEP, 8'h00);  // sweep overflow, channel off

    // random part: mostly a full setup plus trigger followed by a burst of mostly
    // ticks and frame clocks, the rest fully random requests
    while (requests_sent < REQUEST_GOAL) begin
      if ($urandom_range(0, 3) != 0) begin
        quiet = ($urandom_range(0, 7) == 0);
        d = 8'($urandom);
        if ($urandom_range(0, 1) != 0) d[6:4] = 3'd0;
        send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_SWEEP, d);
        d = 8'($urandom);
        if ($urandom_range(0, 2) == 0) d[5:0] = 6'($urandom_range(56, 63));
        send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_DUTY, d);
        d = 8'($urandom);
        if (d[7:3] == 5'd0) d[7:4] = 4'($urandom_range(1, 15));
        send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_ENV, d);
        // high period values most of the time so the duty position really moves
        d = 8'($urandom);
        if ($urandom_range(0, 2) != 0) d[7:5] = 3'b111;
        send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_PER_LO, d);
        d = 8'($urandom);
        d[7] = 1'b1;
        if ($urandom_range(0, 2) != 0) d[2:0] = 3'b111;
        send_request(pcs_pkg::OP_WRITE, pcs_pkg::REG_PER_HI, d);
        run_len = $urandom_range(8, 60);
        repeat (run_len) begin
          r = $urandom_range(0, 99);
          d = 8'($urandom);
          if (r < 45)
            send_request(pcs_pkg::OP_TICK, 3'($urandom_range(0, 7)), d);
          else if (r < 57)
            send_request(pcs_pkg::OP_LENGTH, 3'($urandom_range(0, 7)), d);
          else if (r < 69)
            send_request(pcs_pkg::OP_SWEEP, 3'($urandom_range(0, 7)), d);
          else if (r < 81)
            send_request(pcs_pkg::OP_ENV, 3'($urandom_range(0, 7)), d);
          else if (r < 89)
            send_request(pcs_pkg::OP_READ, 3'($urandom_range(0, 7)), d);
          else if (r < 97)
            send_request(pcs_pkg::OP_WRITE, 3'($urandom_range(0, 4)), d);
          else
            send_request(3'($urandom_range(6, 7)), 3'($urandom_range(0, 7)), d);
        end
      end else begin
        quiet = 1'b0;
        repeat ($urandom_range(1, 8))
          send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 8'($urandom));
      end
      // hold off once until the block has handed over every result
      if (!drained && requests_sent >= REQUEST_GOAL / 2) begin
        in_valid <= 1'b0;
        while (board.predicted_results.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (board.predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
sv/pcs_pkg.sv
sv/pcs_core.sv
sv/pulse_channel_with_sweep.sv
tb/pulse_channel_with_sweep_tb.sv
